// ===== rtl/core/cohtl_pkg.sv =====
`default_nettype none

package cohtl_pkg;

   localparam int HEADER_BYTES = 8;
   localparam int LINE_BYTES   = 64;

   localparam logic [6:0] SIZE_HDR  = 7'(HEADER_BYTES);
   localparam logic [6:0] SIZE_LINE = 7'(LINE_BYTES + HEADER_BYTES);

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_CACHE_KIND = 2'd0;
   localparam logic [1:0] REG_PROTOCOL   = 2'd1;
   localparam logic [1:0] REG_HINT_LEVEL = 2'd2;

   localparam logic [1:0] KIND_PRIMARY_WT  = 2'd0;
   localparam logic [1:0] KIND_PRIMARY_WB  = 2'd1;
   localparam logic [1:0] KIND_SECONDARY_WB = 2'd2;

   typedef enum logic [3:0] {
      CMD_READ          = 4'd0,
      CMD_WRITE         = 4'd1,
      CMD_RMW           = 4'd2,
      CMD_L1WPF         = 4'd3,
      CMD_L1RPF         = 4'd4,
      CMD_L2WPF         = 4'd5,
      CMD_L2RPF         = 4'd6,
      CMD_REPLY_SH      = 4'd7,
      CMD_REPLY_EXCL    = 4'd8,
      CMD_REPLY_EXCLDY  = 4'd9,
      CMD_REPLY_UPGRADE = 4'd10,
      CMD_COPYBACK      = 4'd11,
      CMD_COPYBACK_INVL = 4'd12,
      CMD_INVL          = 4'd13,
      CMD_REPL          = 4'd14
   } cmd_type;

   typedef enum logic [1:0] {
      LS_INVALID    = 2'd0,
      LS_CLEAN_PRIV = 2'd1,
      LS_SHARED     = 2'd2,
      LS_DIRTY      = 2'd3
   } line_state_type;

   localparam logic [2:0] NS_INVALID    = 3'd0;
   localparam logic [2:0] NS_CLEAN_PRIV = 3'd1;
   localparam logic [2:0] NS_SHARED     = 3'd2;
   localparam logic [2:0] NS_DIRTY      = 3'd3;
   localparam logic [2:0] NS_PENDING    = 3'd4;

   localparam logic [4:0] REQ_NONE          = 5'd0;
   localparam logic [4:0] REQ_READ          = 5'd1;
   localparam logic [4:0] REQ_WRITE         = 5'd2;
   localparam logic [4:0] REQ_RMW           = 5'd3;
   localparam logic [4:0] REQ_L1WPF         = 5'd4;
   localparam logic [4:0] REQ_L1RPF         = 5'd5;
   localparam logic [4:0] REQ_L2WPF         = 5'd6;
   localparam logic [4:0] REQ_L2RPF         = 5'd7;
   localparam logic [4:0] REQ_COPYBACK      = 5'd12;
   localparam logic [4:0] REQ_COPYBACK_INVL = 5'd13;
   localparam logic [4:0] REQ_INVL          = 5'd14;
   localparam logic [4:0] REQ_REPL          = 5'd15;
   localparam logic [4:0] REQ_READ_SHARED   = 5'd16;
   localparam logic [4:0] REQ_READ_OWN      = 5'd17;
   localparam logic [4:0] REQ_UPGRADE       = 5'd18;
   localparam logic [4:0] REQ_WRITEBACK     = 5'd19;

   typedef enum logic [1:0] {
      SZ_NONE = 2'd0,
      SZ_HDR  = 2'd1,
      SZ_LINE = 2'd2
   } size_type;

   typedef struct packed {
      logic       valid;
      logic [2:0] nxt;
      logic [4:0] down;
      size_type   dsz;
      size_type   rsz;
      logic [4:0] up;
      size_type   usz;
      logic       noalloc;
   } entry_type;

   localparam entry_type NO_ENTRY = '0;

   typedef struct packed {
      logic [1:0] cache_kind;
      logic       protocol_msi;
      logic [1:0] hint_level;
   } cfg_type;

   typedef struct packed {
      logic           allocate_hint;
      line_state_type line_state;
      logic [3:0]     cmd;
   } item_type;

   typedef struct packed {
      logic       error;
      logic       allocates;
      logic [6:0] up_request_bytes;
      logic [4:0] up_request;
      logic [6:0] reply_bytes;
      logic [6:0] down_request_bytes;
      logic [4:0] down_request;
      logic [2:0] next_state;
   } result_type;

   function automatic entry_type ent(input logic [2:0] nxt, input logic [4:0] down,
                                     input size_type dsz, input size_type rsz,
                                     input logic [4:0] up, input size_type usz,
                                     input logic noalloc);
      entry_type e;
      e.valid   = 1'b1;
      e.nxt     = nxt;
      e.down    = down;
      e.dsz     = dsz;
      e.rsz     = rsz;
      e.up      = up;
      e.usz     = usz;
      e.noalloc = noalloc;
      return e;
   endfunction

   function automatic entry_type keep(input logic [2:0] nxt);
      return ent(nxt, REQ_NONE, SZ_NONE, SZ_NONE, REQ_NONE, SZ_NONE, 1'b0);
   endfunction

   function automatic logic [6:0] size_bytes(input size_type code);
      logic [6:0] v;
      unique case (code)
         SZ_HDR:  v = SIZE_HDR;
         SZ_LINE: v = SIZE_LINE;
         default: v = 7'd0;
      endcase
      return v;
   endfunction

   function automatic entry_type wt_lookup(input logic [3:0] cmd, input line_state_type st);
      entry_type e;
      logic      inv;
      inv = (st == LS_INVALID);
      unique case (cmd)
         CMD_READ: e = inv ? ent(NS_PENDING, REQ_READ, SZ_HDR, SZ_LINE, REQ_NONE, SZ_NONE, 1'b0)
                           : keep(NS_CLEAN_PRIV);
         CMD_WRITE: e = ent(inv ? NS_PENDING : NS_CLEAN_PRIV, REQ_WRITE, SZ_HDR, SZ_HDR,
                            REQ_NONE, SZ_NONE, 1'b1);
         CMD_RMW: e = ent(inv ? NS_PENDING : NS_CLEAN_PRIV, REQ_RMW, SZ_HDR,
                          inv ? SZ_LINE : SZ_HDR, REQ_NONE, SZ_NONE, 1'b0);
         CMD_L1WPF: e = ent(inv ? NS_PENDING : NS_CLEAN_PRIV, REQ_L1WPF, SZ_HDR,
                            inv ? SZ_LINE : SZ_HDR, REQ_NONE, SZ_NONE, 1'b0);
         CMD_L1RPF: e = inv ? ent(NS_PENDING, REQ_L1RPF, SZ_HDR, SZ_LINE, REQ_NONE, SZ_NONE, 1'b0)
                            : keep(NS_CLEAN_PRIV);
         CMD_L2WPF: e = ent(inv ? NS_INVALID : NS_CLEAN_PRIV, REQ_L2WPF, SZ_HDR, SZ_HDR,
                            REQ_NONE, SZ_NONE, inv);
         CMD_L2RPF: e = inv ? ent(NS_INVALID, REQ_L2RPF, SZ_HDR, SZ_HDR, REQ_NONE, SZ_NONE, 1'b1)
                            : keep(NS_CLEAN_PRIV);
         CMD_REPLY_SH: e = inv ? keep(NS_CLEAN_PRIV) : NO_ENTRY;
         CMD_REPLY_EXCL, CMD_REPLY_EXCLDY, CMD_REPLY_UPGRADE: e = keep(NS_CLEAN_PRIV);
         CMD_COPYBACK: e = ent(inv ? NS_INVALID : NS_CLEAN_PRIV, REQ_COPYBACK, SZ_HDR, SZ_HDR,
                               REQ_NONE, SZ_NONE, 1'b0);
         CMD_COPYBACK_INVL: e = ent(NS_INVALID, REQ_COPYBACK_INVL, SZ_HDR, SZ_HDR,
                                    REQ_NONE, SZ_NONE, 1'b0);
         CMD_INVL: e = ent(NS_INVALID, REQ_INVL, SZ_HDR, SZ_HDR, REQ_NONE, SZ_NONE, 1'b0);
         CMD_REPL: e = keep(NS_INVALID);
         default: e = NO_ENTRY;
      endcase
      if (st == LS_SHARED || st == LS_DIRTY) begin
         e = NO_ENTRY;
      end
      return e;
   endfunction

   function automatic entry_type pwb_lookup(input logic [3:0] cmd, input line_state_type st);
      entry_type e;
      entry_type hold;
      logic      inv;
      logic      shd;
      logic      dty;
      hold = keep({1'b0, st});
      inv  = (st == LS_INVALID);
      shd  = (st == LS_SHARED);
      dty  = (st == LS_DIRTY);
      unique case (cmd)
         CMD_READ: e = inv ? ent(NS_PENDING, REQ_READ, SZ_HDR, SZ_LINE, REQ_NONE, SZ_NONE, 1'b0)
                           : hold;
         CMD_WRITE, CMD_RMW: begin
            if (inv || shd) begin
               e = ent(NS_PENDING, (cmd == CMD_WRITE) ? REQ_WRITE : REQ_RMW, SZ_HDR,
                       inv ? SZ_LINE : SZ_HDR, REQ_NONE, SZ_NONE, 1'b0);
            end else begin
               e = keep(NS_DIRTY);
            end
         end
         CMD_L1WPF: e = (inv || shd) ? ent(NS_PENDING, REQ_L1WPF, SZ_HDR, inv ? SZ_LINE : SZ_HDR,
                                           REQ_NONE, SZ_NONE, 1'b0) : hold;
         CMD_L1RPF: e = inv ? ent(NS_PENDING, REQ_L1RPF, SZ_HDR, SZ_LINE, REQ_NONE, SZ_NONE, 1'b0)
                            : hold;
         CMD_L2WPF: e = (inv || shd) ? ent(inv ? NS_INVALID : NS_SHARED, REQ_L2WPF, SZ_HDR, SZ_HDR,
                                           REQ_NONE, SZ_NONE, inv) : hold;
         CMD_L2RPF: e = inv ? ent(NS_INVALID, REQ_L2RPF, SZ_HDR, SZ_HDR, REQ_NONE, SZ_NONE, 1'b1)
                            : hold;
         CMD_REPLY_SH: e = inv ? keep(NS_SHARED) : NO_ENTRY;
         CMD_REPLY_EXCL, CMD_REPLY_UPGRADE: e = (inv || shd) ? keep(NS_CLEAN_PRIV) : NO_ENTRY;
         CMD_REPLY_EXCLDY: e = inv ? keep(NS_CLEAN_PRIV) : NO_ENTRY;
         CMD_COPYBACK: e = ent(inv ? NS_INVALID : NS_SHARED, REQ_COPYBACK, dty ? SZ_LINE : SZ_HDR,
                               dty ? SZ_LINE : SZ_HDR, REQ_NONE, SZ_NONE, 1'b0);
         CMD_COPYBACK_INVL: e = ent(NS_INVALID, REQ_COPYBACK_INVL, dty ? SZ_LINE : SZ_HDR,
                                    dty ? SZ_LINE : SZ_HDR, REQ_NONE, SZ_NONE, 1'b0);
         CMD_INVL: e = ent(NS_INVALID, REQ_INVL, SZ_HDR, SZ_HDR, REQ_NONE, SZ_NONE, 1'b0);
         CMD_REPL: e = dty ? ent(NS_INVALID, REQ_WRITEBACK, SZ_LINE, SZ_HDR, REQ_NONE, SZ_NONE, 1'b0)
                           : keep(NS_INVALID);
         default: e = NO_ENTRY;
      endcase
      return e;
   endfunction

   function automatic entry_type swb_lookup(input logic [3:0] cmd, input line_state_type st,
                                            input logic msi, input logic [1:0] hint_level);
      entry_type  e;
      entry_type  hold;
      logic [2:0] excl;
      logic       inv;
      logic       prv;
      logic       shd;
      logic       dty;
      logic       hint_on;
      hold    = keep({1'b0, st});
      excl    = msi ? NS_DIRTY : NS_CLEAN_PRIV;
      inv     = (st == LS_INVALID);
      prv     = (st == LS_CLEAN_PRIV);
      shd     = (st == LS_SHARED);
      dty     = (st == LS_DIRTY);
      hint_on = shd ? hint_level[1] : (hint_level != 2'd0);
      unique case (cmd)
         CMD_READ, CMD_L1RPF, CMD_L2RPF:
            e = inv ? ent(NS_PENDING, REQ_READ_SHARED, SZ_HDR, SZ_LINE, REQ_NONE, SZ_NONE, 1'b0)
                    : hold;
         CMD_WRITE, CMD_RMW, CMD_L1WPF, CMD_L2WPF: begin
            if (inv) begin
               e = ent(NS_PENDING, REQ_READ_OWN, SZ_HDR, SZ_LINE, REQ_NONE, SZ_NONE, 1'b0);
            end else if (shd) begin
               e = ent(NS_PENDING, REQ_UPGRADE, SZ_HDR, SZ_HDR, REQ_NONE, SZ_NONE, 1'b0);
            end else if (prv && (cmd == CMD_WRITE || cmd == CMD_RMW)) begin
               e = keep(NS_DIRTY);
            end else begin
               e = hold;
            end
         end
         CMD_REPLY_SH: e = inv ? keep(NS_SHARED) : NO_ENTRY;
         CMD_REPLY_EXCL: e = inv ? keep(excl) : NO_ENTRY;
         CMD_REPLY_EXCLDY: e = inv ? keep(NS_DIRTY) : NO_ENTRY;
         CMD_REPLY_UPGRADE: e = shd ? keep(excl) : NO_ENTRY;
         CMD_COPYBACK: e = ent(inv ? NS_INVALID : NS_SHARED, REQ_COPYBACK,
                               (prv || dty) ? SZ_LINE : SZ_HDR, dty ? SZ_LINE : SZ_HDR,
                               REQ_NONE, SZ_NONE, 1'b0);
         CMD_COPYBACK_INVL: e = ent(NS_INVALID, REQ_COPYBACK_INVL,
                                    (prv || dty) ? SZ_LINE : SZ_HDR, dty ? SZ_LINE : SZ_HDR,
                                    REQ_NONE, SZ_NONE, 1'b0);
         CMD_INVL: e = ent(NS_INVALID, REQ_INVL, SZ_HDR, SZ_HDR, REQ_NONE, SZ_NONE, 1'b0);
         CMD_REPL: begin
            if (inv) begin
               e = keep(NS_INVALID);
            end else if (dty) begin
               e = ent(NS_INVALID, REQ_WRITEBACK, SZ_LINE, SZ_HDR, REQ_COPYBACK_INVL, SZ_HDR,
                       1'b0);
            end else if (hint_on) begin
               e = ent(NS_INVALID, REQ_REPL, SZ_HDR, SZ_HDR,
                       shd ? REQ_INVL : REQ_COPYBACK_INVL, SZ_HDR, 1'b0);
            end else begin
               e = ent(NS_INVALID, REQ_NONE, SZ_NONE, SZ_NONE,
                       shd ? REQ_INVL : REQ_COPYBACK_INVL, SZ_HDR, 1'b0);
            end
         end
         default: e = NO_ENTRY;
      endcase
      return e;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cohtl_csr.sv =====
`default_nettype none

module cohtl_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [cohtl_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [cohtl_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic      [cohtl_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                     csr_pready,
   output cohtl_pkg::cfg_type                       cfg
);

   cohtl_pkg::cfg_type cfg_ff;
   cohtl_pkg::cfg_type cfg_in;
   logic [1:0]         reg_index;
   logic               write_en;

   assign reg_index  = csr_paddr[3:2];
   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (reg_index)
            cohtl_pkg::REG_CACHE_KIND: cfg_in.cache_kind   = csr_pwdata[1:0];
            cohtl_pkg::REG_PROTOCOL:   cfg_in.protocol_msi = csr_pwdata[0];
            cohtl_pkg::REG_HINT_LEVEL: cfg_in.hint_level   = csr_pwdata[1:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cache_kind   <= cohtl_pkg::KIND_PRIMARY_WB;
         cfg_ff.protocol_msi <= 1'b0;
         cfg_ff.hint_level   <= 2'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_index)
         cohtl_pkg::REG_CACHE_KIND: csr_prdata = {30'd0, cfg_ff.cache_kind};
         cohtl_pkg::REG_PROTOCOL:   csr_prdata = {31'd0, cfg_ff.protocol_msi};
         cohtl_pkg::REG_HINT_LEVEL: csr_prdata = {30'd0, cfg_ff.hint_level};
         default:                   csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/core/cohtl_lookup.sv =====
`default_nettype none

module cohtl_lookup (
   input  wire cohtl_pkg::cfg_type  cfg,
   input  wire cohtl_pkg::item_type item,
   output cohtl_pkg::result_type    result
);

   cohtl_pkg::entry_type e;

   always_comb begin
      unique case (cfg.cache_kind)
         cohtl_pkg::KIND_PRIMARY_WT:
            e = cohtl_pkg::wt_lookup(item.cmd, item.line_state);
         cohtl_pkg::KIND_PRIMARY_WB:
            e = cohtl_pkg::pwb_lookup(item.cmd, item.line_state);
         cohtl_pkg::KIND_SECONDARY_WB:
            e = cohtl_pkg::swb_lookup(item.cmd, item.line_state, cfg.protocol_msi,
                                      cfg.hint_level);
         default:
            e = cohtl_pkg::NO_ENTRY;
      endcase
   end

   always_comb begin
      result = '0;
      if (e.valid) begin
         result.next_state         = e.nxt;
         result.down_request       = e.down;
         result.down_request_bytes = cohtl_pkg::size_bytes(e.dsz);
         result.reply_bytes        = cohtl_pkg::size_bytes(e.rsz);
         result.up_request         = e.up;
         result.up_request_bytes   = cohtl_pkg::size_bytes(e.usz);
         result.allocates          = (item.line_state != cohtl_pkg::LS_INVALID)
                                     || item.allocate_hint || !e.noalloc;
      end else begin
         result.error = 1'b1;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/coherence_transition_lookup.sv =====
// Channel        | Direction | Transaction contents
// req (stream)   | in        | tdata: cmd, line_state, allocate_hint
// rsp (stream)   | out       | tdata: state, requests, sizes, allocates; tuser: error
// csr (APB)      | in/out    | cache_kind, protocol_msi, replacement_hint_level
//
// Each transaction is registered on entry, looked up combinationally in the fixed transition tables
// and registered again on exit, so a result is offered on rsp from the output register.
// One transaction is accepted per cycle while rsp does not stall; there are two register stages.
// Synchronous reset empties both stages and restores the configuration defaults.
// A stall on rsp holds the output stage, and the input stage then accepts only while it is empty.
`default_nettype none

module coherence_transition_lookup (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // [3:0] cmd, [5:4] line_state, [6] allocate_hint, [7] zero
   input  wire logic [7:0]                       req_tdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [2:0] next_state, [7:3] down_request, [14:8] down_request_bytes,
   // [21:15] reply_bytes, [26:22] up_request, [33:27] up_request_bytes,
   // [34] allocates, [39:35] zero
   output logic      [39:0]                      rsp_tdata,
   // [0] error
   output logic                                  rsp_tuser,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [cohtl_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [cohtl_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [cohtl_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                  csr_pready
);

   cohtl_pkg::cfg_type    cfg;
   cohtl_pkg::item_type   item_ff;
   cohtl_pkg::item_type   item_in;
   logic                  item_valid_ff;
   logic                  item_valid_in;
   cohtl_pkg::result_type lookup_result;
   cohtl_pkg::result_type result_ff;
   cohtl_pkg::result_type result_in;
   logic                  result_valid_ff;
   logic                  result_valid_in;
   logic                  out_ready;

   cohtl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cohtl_lookup u_lookup (
      .cfg    (cfg),
      .item   (item_ff),
      .result (lookup_result)
   );

   assign out_ready  = !result_valid_ff || rsp_tready;
   assign req_tready = !item_valid_ff || out_ready;

   always_comb begin
      item_in       = item_ff;
      item_valid_in = item_valid_ff;
      if (req_tready) begin
         item_valid_in = req_tvalid;
         item_in       = cohtl_pkg::item_type'(req_tdata[6:0]);
      end
      result_in       = result_ff;
      result_valid_in = result_valid_ff;
      if (out_ready) begin
         result_valid_in = item_valid_ff;
         result_in       = lookup_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff   <= 1'b0;
         result_valid_ff <= 1'b0;
      end else begin
         item_valid_ff   <= item_valid_in;
         result_valid_ff <= result_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      result_ff <= result_in;
   end

   assign rsp_tvalid = result_valid_ff;
   assign rsp_tuser  = result_ff.error;
   assign rsp_tdata  = {5'd0,
                        result_ff.allocates,
                        result_ff.up_request_bytes,
                        result_ff.up_request,
                        result_ff.reply_bytes,
                        result_ff.down_request_bytes,
                        result_ff.down_request,
                        result_ff.next_state};

endmodule

`default_nettype wire
